// ===== rtl/tbu_pkg.sv =====
package tbu_pkg;

  // Default widths
  localparam int unsigned COORD_WIDTH_DEF   = 32;
  localparam int unsigned OUT_FRAC_BITS_DEF = 14;

  // Significant bits kept of the largest component before normalising
  localparam int unsigned SIG_BITS = 30;

  // Job queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;

  // Number of products formed per triangle (det, tangent, bitangent)
  localparam int unsigned NUM_PRODUCTS = 14;
  localparam int unsigned NUM_RESULTS  = 7;

  // Corner position within a triangle
  localparam logic [1:0] CORNER_FIRST  = 2'd0;
  localparam logic [1:0] CORNER_SECOND = 2'd1;
  localparam logic [1:0] CORNER_THIRD  = 2'd2;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL,
    BK_CHECK,
    BK_LOAD,
    BK_SHIFT,
    BK_SQUARE,
    BK_SQRT,
    BK_DIVLD,
    BK_DIV,
    BK_OUT
  } back_state_e;

endpackage

// ===== rtl/tbu_front.sv =====
module tbu_front #(
  parameter int unsigned COORD_WIDTH = tbu_pkg::COORD_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [COORD_WIDTH-1:0]         pos_x_i,
  input  logic [COORD_WIDTH-1:0]         pos_y_i,
  input  logic [COORD_WIDTH-1:0]         pos_z_i,
  input  logic [COORD_WIDTH-1:0]         tex_u_i,
  input  logic [COORD_WIDTH-1:0]         tex_v_i,
  output logic                           job_valid_o,
  input  logic                           job_ready_i,
  // du1, dv1, du2, dv2, e1 x/y/z, e2 x/y/z from the lowest bit up
  output logic [10*(COORD_WIDTH+1)-1:0]  job_data_o
);
  import tbu_pkg::*;

  localparam int unsigned DW = COORD_WIDTH + 1;

  logic [1:0]             cnt_q, cnt_d;
  logic [COORD_WIDTH-1:0] held_pos_q [6];
  logic [COORD_WIDTH-1:0] held_tex_q [4];
  logic                   accept;
  logic [DW-1:0]          e1x, e1y, e1z, e2x, e2y, e2z, du1, dv1, du2, dv2;

  // Hold the first two corners; the third needs room in the queue
  assign in_ready_o  = (cnt_q != CORNER_THIRD) || job_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign job_valid_o = in_valid_i && (cnt_q == CORNER_THIRD);

  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      cnt_d = (cnt_q == CORNER_THIRD) ? CORNER_FIRST : cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CORNER_FIRST;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Capture corner one and two
  always_ff @(posedge clk_i) begin
    if (accept && cnt_q == CORNER_FIRST) begin
      held_pos_q[0] <= pos_x_i;
      held_pos_q[1] <= pos_y_i;
      held_pos_q[2] <= pos_z_i;
      held_tex_q[0] <= tex_u_i;
      held_tex_q[1] <= tex_v_i;
    end
    if (accept && cnt_q == CORNER_SECOND) begin
      held_pos_q[3] <= pos_x_i;
      held_pos_q[4] <= pos_y_i;
      held_pos_q[5] <= pos_z_i;
      held_tex_q[2] <= tex_u_i;
      held_tex_q[3] <= tex_v_i;
    end
  end

  // Edge and texture deltas, sign extended by one bit
  assign e1x = {held_pos_q[3][COORD_WIDTH-1], held_pos_q[3]}
             - {held_pos_q[0][COORD_WIDTH-1], held_pos_q[0]};
  assign e1y = {held_pos_q[4][COORD_WIDTH-1], held_pos_q[4]}
             - {held_pos_q[1][COORD_WIDTH-1], held_pos_q[1]};
  assign e1z = {held_pos_q[5][COORD_WIDTH-1], held_pos_q[5]}
             - {held_pos_q[2][COORD_WIDTH-1], held_pos_q[2]};
  assign e2x = {pos_x_i[COORD_WIDTH-1], pos_x_i}
             - {held_pos_q[0][COORD_WIDTH-1], held_pos_q[0]};
  assign e2y = {pos_y_i[COORD_WIDTH-1], pos_y_i}
             - {held_pos_q[1][COORD_WIDTH-1], held_pos_q[1]};
  assign e2z = {pos_z_i[COORD_WIDTH-1], pos_z_i}
             - {held_pos_q[2][COORD_WIDTH-1], held_pos_q[2]};
  assign du1 = {held_tex_q[2][COORD_WIDTH-1], held_tex_q[2]}
             - {held_tex_q[0][COORD_WIDTH-1], held_tex_q[0]};
  assign dv1 = {held_tex_q[3][COORD_WIDTH-1], held_tex_q[3]}
             - {held_tex_q[1][COORD_WIDTH-1], held_tex_q[1]};
  assign du2 = {tex_u_i[COORD_WIDTH-1], tex_u_i}
             - {held_tex_q[0][COORD_WIDTH-1], held_tex_q[0]};
  assign dv2 = {tex_v_i[COORD_WIDTH-1], tex_v_i}
             - {held_tex_q[1][COORD_WIDTH-1], held_tex_q[1]};

  assign job_data_o = {e2z, e2y, e2x, e1z, e1y, e1x, dv2, du2, dv1, du1};

endmodule

// ===== rtl/tbu_queue.sv =====
module tbu_queue #(
  parameter int unsigned DATA_W = 10 * (tbu_pkg::COORD_WIDTH_DEF + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output logic [DATA_W-1:0] rd_data_o
);
  import tbu_pkg::*;

  logic [DATA_W-1:0] mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   cnt_q;
  logic              push, pop;

  assign wr_ready_o = (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rd_ptr_q];

  // Advance pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (push && !pop) cnt_q <= cnt_q + 1'b1;
      else if (pop && !push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

// ===== rtl/tbu_back.sv =====
module tbu_back #(
  parameter int unsigned COORD_WIDTH   = tbu_pkg::COORD_WIDTH_DEF,
  parameter int unsigned OUT_FRAC_BITS = tbu_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            job_valid_i,
  output logic                            job_ready_o,
  input  logic [10*(COORD_WIDTH+1)-1:0]   job_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  // tangent x/y/z, bitangent x/y/z from the lowest bit up
  output logic [6*(OUT_FRAC_BITS+2)-1:0]  out_comp_o,
  output logic                            out_degenerate_o
);
  import tbu_pkg::*;

  localparam int unsigned DW  = COORD_WIDTH + 1;
  localparam int unsigned PW  = 2 * DW;
  localparam int unsigned MW  = PW + 1;
  localparam int unsigned OW  = OUT_FRAC_BITS + 2;
  localparam int unsigned SW  = 2 * SIG_BITS + 2;
  localparam int unsigned RTW = SIG_BITS + 1;
  localparam int unsigned RMW = SIG_BITS + 4;
  localparam int unsigned DRW = RTW + 1;
  localparam int unsigned NW  = SIG_BITS + OUT_FRAC_BITS + 1;
  localparam int unsigned CW  = $clog2(NW + 32);

  back_state_e state_q, state_d;

  logic signed [DW-1:0] du1_q, dv1_q, du2_q, dv2_q;
  logic signed [DW-1:0] e1_q [3];
  logic signed [DW-1:0] e2_q [3];
  logic signed [PW-1:0] prod_q, first_q, prod_d;
  logic signed [MW-1:0] res_q [NUM_RESULTS];
  logic signed [MW-1:0] diff;
  logic [MW-1:0]        mag_q [3];
  logic [2:0]           neg_q;
  logic [CW-1:0]        cnt_q;
  logic [1:0]           kc_q;
  logic                 vsel_q, deg_q;
  logic [SW-1:0]        sum_q;
  logic [RTW-1:0]       root_q;
  logic [RMW-1:0]       srem_q;
  logic [NW-1:0]        num_q, qt_q;
  logic [DRW-1:0]       drem_q;
  logic [OW-1:0]        comp_q [6];
  logic [OW-1:0]        obuf_q [6];
  logic                 out_valid_q, out_deg_q;

  logic [2:0]            step_j;
  logic                  step_second;
  logic [1:0]            kidx;
  logic signed [DW-1:0]  opa, opb;
  logic [MW-1:0]         or_v;
  logic [SIG_BITS-1:0]   m_sel;
  logic [SW-1:0]         sq;
  logic [RMW-1:0]        srem_n, strial;
  logic [DRW-1:0]        drem_n;
  logic                  dge;
  logic [NW-1:0]         qt_n;
  logic [OW-1:0]         qv, qsigned;
  logic [2:0]            cidx;
  logic                  flip, det_zero, out_load;

  // Select the operands of the current product
  assign step_j      = cnt_q[3:1];
  assign step_second = cnt_q[0];

  always_comb begin
    kidx = '0;
    opa  = du1_q;
    opb  = dv2_q;
    if (step_j == 3'd0) begin
      opa = step_second ? du2_q : du1_q;
      opb = step_second ? dv1_q : dv2_q;
    end else if (step_j < 3'd4) begin
      kidx = 2'(step_j - 3'd1);
      opa  = step_second ? dv1_q : dv2_q;
      opb  = step_second ? e2_q[kidx] : e1_q[kidx];
    end else begin
      kidx = 2'(step_j - 3'd4);
      opa  = step_second ? du2_q : du1_q;
      opb  = step_second ? e1_q[kidx] : e2_q[kidx];
    end
  end

  assign prod_d   = PW'(opa) * PW'(opb);
  assign diff     = MW'(first_q) - MW'(prod_q);
  assign flip     = res_q[0][MW-1];
  assign det_zero = (res_q[0] == '0);

  // Leading-bit search and squaring
  assign or_v  = mag_q[0] | mag_q[1] | mag_q[2];
  assign m_sel = mag_q[kc_q][MW-1 -: SIG_BITS];
  assign sq    = SW'(m_sel) * SW'(m_sel);

  // One root bit per step
  assign srem_n = {srem_q[RMW-3:0], sum_q[SW-1 -: 2]};
  assign strial = RMW'({root_q, 2'b01});

  // One quotient bit per step
  assign drem_n  = {drem_q[DRW-2:0], num_q[NW-1]};
  assign dge     = (drem_n >= DRW'(root_q));
  assign qt_n    = {qt_q[NW-2:0], dge};
  assign qv      = qt_n[OW-1:0];
  assign qsigned = (neg_q[kc_q] ^ flip) ? (OW'(0) - qv) : qv;
  assign cidx    = vsel_q ? (3'd3 + 3'(kc_q)) : 3'(kc_q);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE:   if (job_valid_i) state_d = BK_MUL;
      BK_MUL:    if (cnt_q == CW'(NUM_PRODUCTS)) state_d = BK_CHECK;
      BK_CHECK:  state_d = det_zero ? BK_OUT : BK_LOAD;
      BK_LOAD:   state_d = BK_SHIFT;
      BK_SHIFT: begin
        if (or_v == '0) state_d = BK_OUT;
        else if (or_v[MW-1]) state_d = BK_SQUARE;
      end
      BK_SQUARE: if (kc_q == 2'd2) state_d = BK_SQRT;
      BK_SQRT:   if (cnt_q == CW'(RTW - 1)) state_d = BK_DIVLD;
      BK_DIVLD:  state_d = BK_DIV;
      BK_DIV: begin
        if (cnt_q == CW'(NW - 1)) begin
          if (kc_q != 2'd2) state_d = BK_DIVLD;
          else state_d = vsel_q ? BK_OUT : BK_LOAD;
        end
      end
      BK_OUT:    if (out_load) state_d = BK_IDLE;
      default:   state_d = BK_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    job_ready_o = (state_q == BK_IDLE);
    out_load    = (state_q == BK_OUT) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          du1_q  <= job_i[0*DW +: DW];
          dv1_q  <= job_i[1*DW +: DW];
          du2_q  <= job_i[2*DW +: DW];
          dv2_q  <= job_i[3*DW +: DW];
          e1_q[0] <= job_i[4*DW +: DW];
          e1_q[1] <= job_i[5*DW +: DW];
          e1_q[2] <= job_i[6*DW +: DW];
          e2_q[0] <= job_i[7*DW +: DW];
          e2_q[1] <= job_i[8*DW +: DW];
          e2_q[2] <= job_i[9*DW +: DW];
          cnt_q  <= '0;
          deg_q  <= 1'b0;
          vsel_q <= 1'b0;
        end
      end
      BK_MUL: begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q < CW'(NUM_PRODUCTS)) prod_q <= prod_d;
        if (cnt_q[0]) begin
          first_q <= prod_q;
        end else if (cnt_q != '0) begin
          for (int i = 0; i < NUM_RESULTS - 1; i++) res_q[i] <= res_q[i+1];
          res_q[NUM_RESULTS-1] <= diff;
        end
      end
      BK_CHECK: begin
        if (det_zero) deg_q <= 1'b1;
      end
      BK_LOAD: begin
        for (int k = 0; k < 3; k++) begin
          neg_q[k] <= vsel_q ? res_q[4+k][MW-1] : res_q[1+k][MW-1];
          if (vsel_q) mag_q[k] <= res_q[4+k][MW-1] ? MW'(-res_q[4+k]) : MW'(res_q[4+k]);
          else        mag_q[k] <= res_q[1+k][MW-1] ? MW'(-res_q[1+k]) : MW'(res_q[1+k]);
        end
      end
      BK_SHIFT: begin
        kc_q  <= '0;
        sum_q <= '0;
        if (or_v == '0) begin
          deg_q <= 1'b1;
        end else if (!or_v[MW-1]) begin
          for (int k = 0; k < 3; k++) begin
            if (or_v[MW-1 -: 8] == '0) mag_q[k] <= mag_q[k] << 8;
            else mag_q[k] <= mag_q[k] << 1;
          end
        end
      end
      BK_SQUARE: begin
        sum_q  <= sum_q + sq;
        kc_q   <= kc_q + 2'd1;
        root_q <= '0;
        srem_q <= '0;
        cnt_q  <= '0;
      end
      BK_SQRT: begin
        cnt_q <= cnt_q + 1'b1;
        sum_q <= sum_q << 2;
        if (srem_n >= strial) begin
          srem_q <= srem_n - strial;
          root_q <= {root_q[RTW-2:0], 1'b1};
        end else begin
          srem_q <= srem_n;
          root_q <= {root_q[RTW-2:0], 1'b0};
        end
        kc_q <= '0;
      end
      BK_DIVLD: begin
        num_q  <= NW'({m_sel, OUT_FRAC_BITS'(0)}) + NW'(root_q[RTW-1:1]);
        drem_q <= '0;
        qt_q   <= '0;
        cnt_q  <= '0;
      end
      BK_DIV: begin
        cnt_q  <= cnt_q + 1'b1;
        num_q  <= num_q << 1;
        qt_q   <= qt_n;
        drem_q <= dge ? (drem_n - DRW'(root_q)) : drem_n;
        if (cnt_q == CW'(NW - 1)) begin
          comp_q[cidx] <= qsigned;
          kc_q <= kc_q + 2'd1;
          if (kc_q == 2'd2) vsel_q <= 1'b1;
        end
      end
      BK_OUT: begin
        if (out_load) begin
          for (int i = 0; i < 6; i++) obuf_q[i] <= deg_q ? '0 : comp_q[i];
          out_deg_q <= deg_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o      = out_valid_q;
  assign out_degenerate_o = out_deg_q;
  always_comb begin
    for (int i = 0; i < 6; i++) out_comp_o[i*OW +: OW] = obuf_q[i];
  end

  // A degenerate word carries all-zero vectors
  a_deg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_degenerate_o |-> out_comp_o == '0)
    else $error("degenerate word with non-zero vector");

  // Division only runs with a non-zero length
  a_div_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_DIV |-> root_q != '0)
    else $error("division by zero length");

  // Squaring starts only once the leading bit is in place
  a_sq_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_SQUARE |-> or_v[MW-1])
    else $error("vector not normalised before squaring");

  // A taken job starts the product sequence from its first step
  a_job_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i && job_ready_o |=> state_q == BK_MUL && cnt_q == '0)
    else $error("job not started");

endmodule

// ===== rtl/triangle_tangent_basis_unit.sv =====
// Per triangle, after the third corner, the back end forms the products on one shared
//   multiplier and then, for each of the two vectors, runs a leading-bit search, a
//   bit-serial square root and a bit-serial division per component; these set the rate
//   of triangles. It takes a new job only when idle, while further jobs wait in the queue.
// Corners are taken one per cycle while the two-deep job queue has room.
// Reset clears the corner count, the queue and the output valid; held data is not cleared.
module triangle_tangent_basis_unit #(
  parameter int unsigned COORD_WIDTH   = tbu_pkg::COORD_WIDTH_DEF,
  parameter int unsigned OUT_FRAC_BITS = tbu_pkg::OUT_FRAC_BITS_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // pos_x, pos_y, pos_z, tex_u, tex_v from the lowest bit up
  input  logic [((5*COORD_WIDTH+7)/8)*8-1:0]          s_axis_tdata_i,
  output logic                                        m_axis_tvalid_o,
  input  logic                                        m_axis_tready_i,
  // tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z
  output logic [((6*(OUT_FRAC_BITS+2)+7)/8)*8-1:0]    m_axis_tdata_o,
  // degenerate
  output logic [0:0]                                  m_axis_tuser_o
);
  import tbu_pkg::*;

  localparam int unsigned JW     = 10 * (COORD_WIDTH + 1);
  localparam int unsigned OW     = OUT_FRAC_BITS + 2;
  localparam int unsigned OUT_DW = ((6*OW+7)/8)*8;

  logic          fj_valid, fj_ready, bj_valid, bj_ready, deg;
  logic [JW-1:0] fj_data, bj_data;
  logic [6*OW-1:0] comps;

  tbu_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .pos_x_i    (s_axis_tdata_i[0*COORD_WIDTH +: COORD_WIDTH]),
    .pos_y_i    (s_axis_tdata_i[1*COORD_WIDTH +: COORD_WIDTH]),
    .pos_z_i    (s_axis_tdata_i[2*COORD_WIDTH +: COORD_WIDTH]),
    .tex_u_i    (s_axis_tdata_i[3*COORD_WIDTH +: COORD_WIDTH]),
    .tex_v_i    (s_axis_tdata_i[4*COORD_WIDTH +: COORD_WIDTH]),
    .job_valid_o(fj_valid),
    .job_ready_i(fj_ready),
    .job_data_o (fj_data)
  );

  tbu_queue #(.DATA_W(JW)) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(fj_valid),
    .wr_ready_o(fj_ready),
    .wr_data_i (fj_data),
    .rd_valid_o(bj_valid),
    .rd_ready_i(bj_ready),
    .rd_data_o (bj_data)
  );

  tbu_back #(
    .COORD_WIDTH  (COORD_WIDTH),
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_valid_i     (bj_valid),
    .job_ready_o     (bj_ready),
    .job_i           (bj_data),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_comp_o      (comps),
    .out_degenerate_o(deg)
  );

  assign m_axis_tdata_o = OUT_DW'(comps);
  assign m_axis_tuser_o = deg;

endmodule
